/* src/bitmap_rect_blitter_defines.svh */
// Assertion macros used by the checker file
`ifndef BITMAP_RECT_BLITTER_DEFINES_SVH
`define BITMAP_RECT_BLITTER_DEFINES_SVH

// clocked check, ignored while reset is asserted
`define BMB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define BMB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bmb_pkg.sv */
package bmb_pkg;

	// wide enough for coordinate + extent sums and plane sizes up to 256
	localparam int SUM_W = 10;
	localparam int QDEPTH = 2;

	localparam logic [3:0] REQ_WSRC  = 4'd0;
	localparam logic [3:0] REQ_WDST  = 4'd1;
	localparam logic [3:0] REQ_RDST  = 4'd2;
	localparam logic [3:0] REQ_COPY  = 4'd3;
	localparam logic [3:0] REQ_VFLIP = 4'd4;
	localparam logic [3:0] REQ_HFLIP = 4'd5;
	localparam logic [3:0] REQ_ROT   = 4'd6;
	localparam logic [3:0] REQ_OR    = 4'd7;
	localparam logic [3:0] REQ_XOR   = 4'd8;

	typedef enum logic [3:0] {
		K_WSRC,
		K_WDST,
		K_RDST,
		K_COPY,
		K_VFLIP,
		K_HFLIP,
		K_ROT,
		K_OR,
		K_XOR,
		K_REJ
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [SUM_W-1:0] sr;
		logic [SUM_W-1:0] sc;
		logic [SUM_W-1:0] dr;
		logic [SUM_W-1:0] dc;
		logic [SUM_W-1:0] rw;
		logic [SUM_W-1:0] rh;
		logic             pv;
	} job_t;

endpackage

/* src/bmb_ifs.sv */
interface bmb_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] req_type;
	logic [5:0] from_col;
	logic [5:0] from_row;
	logic [5:0] to_col;
	logic [5:0] to_row;
	logic [6:0] rect_width;
	logic [6:0] rect_height;
	logic       pixel_value;

	modport source (output valid, req_type, from_col, from_row, to_col, to_row,
		rect_width, rect_height, pixel_value, input ready);
	modport sink (input valid, req_type, from_col, from_row, to_col, to_row,
		rect_width, rect_height, pixel_value, output ready);
endinterface

interface bmb_rsp_if;
	logic valid;
	logic ready;
	logic read_value;
	logic cmd_status;

	modport source (output valid, read_value, cmd_status, input ready);
	modport sink (input valid, read_value, cmd_status, output ready);
endinterface

/* src/bmb_ram.sv */
module bmb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/bmb_front.sv */
module bmb_front import bmb_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic [6:0] width_reg,
	input  logic [6:0] height_reg,
	input  logic [3:0] req_type,
	input  logic [5:0] from_col,
	input  logic [5:0] from_row,
	input  logic [5:0] to_col,
	input  logic [5:0] to_row,
	input  logic [6:0] rect_width,
	input  logic [6:0] rect_height,
	input  logic       pixel_value,
	output job_t       job
);
	logic [SUM_W-1:0] w, h, fc, fr, tc, tr, rw, rh, side_h;
	logic             oob_px, oob_rect;

	always_comb begin
		if (width_reg == 7'd0) w = SUM_W'(1);
		else if (SUM_W'(width_reg) > SUM_W'(MAX_WIDTH)) w = SUM_W'(MAX_WIDTH);
		else w = SUM_W'(width_reg);
		if (height_reg == 7'd0) h = SUM_W'(1);
		else if (SUM_W'(height_reg) > SUM_W'(MAX_HEIGHT)) h = SUM_W'(MAX_HEIGHT);
		else h = SUM_W'(height_reg);
	end

	assign fc = SUM_W'(from_col);
	assign fr = SUM_W'(from_row);
	assign tc = SUM_W'(to_col);
	assign tr = SUM_W'(to_row);
	assign rw = SUM_W'(rect_width);
	assign rh = SUM_W'(rect_height);
	// rotate works on a square of side rect_width
	assign side_h = (req_type == REQ_ROT) ? rw : rh;
	assign oob_px = (tc >= w) || (tr >= h);
	assign oob_rect = (fc + rw > w) || (tc + rw > w) || (fr + side_h > h) || (tr + side_h > h);

	always_comb begin
		job.kind = K_REJ;
		job.sr = fr;
		job.sc = fc;
		job.dr = tr;
		job.dc = tc;
		job.rw = rw;
		job.rh = side_h;
		job.pv = pixel_value;
		case (req_type)
			REQ_WSRC, REQ_WDST, REQ_RDST: begin
				job.sr = tr;
				job.sc = tc;
				job.rw = SUM_W'(1);
				job.rh = SUM_W'(1);
				if (oob_px) job.kind = K_REJ;
				else if (req_type == REQ_WSRC) job.kind = K_WSRC;
				else if (req_type == REQ_WDST) job.kind = K_WDST;
				else job.kind = K_RDST;
			end
			REQ_COPY: job.kind = oob_rect ? K_REJ : K_COPY;
			REQ_VFLIP: job.kind = oob_rect ? K_REJ : K_VFLIP;
			REQ_HFLIP: job.kind = oob_rect ? K_REJ : K_HFLIP;
			REQ_ROT: job.kind = oob_rect ? K_REJ : K_ROT;
			REQ_OR, REQ_XOR: begin
				job.kind = (req_type == REQ_OR) ? K_OR : K_XOR;
				job.sr = '0;
				job.sc = '0;
				job.dr = '0;
				job.dc = '0;
				job.rw = w;
				job.rh = h;
			end
			default: job.kind = K_REJ;
		endcase
	end
endmodule

/* src/bmb_queue.sv */
module bmb_queue import bmb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic empty
);
	job_t                       ent_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0]  wp_q, rp_q;
	logic [$clog2(QDEPTH):0]    cnt_q;

	assign full = (cnt_q == ($clog2(QDEPTH)+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

/* src/bmb_back.sv */
module bmb_back import bmb_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic res_valid,
	input  logic res_ready,
	output logic res_read,
	output logic res_status
);
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RB = $clog2(MAX_HEIGHT);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WRITE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t           state_q;
	job_t             job_q;
	logic [SUM_W-1:0] r_q, c_q;
	logic [SUM_W-1:0] srow, scol, drow, dcol;
	logic [RB-1:0]    srow_q, drow_q;
	logic [CB-1:0]    scol_q, dcol_q;
	logic             svld_q, dvld_q, rd_q;
	logic             res_valid_q, res_read_q, res_status_q;
	logic [MAX_HEIGHT-1:0] src_vld_q, dst_vld_q;

	logic [MAX_WIDTH-1:0] src_rdata, dst_rdata, src_row, dst_row, wrow;
	logic                 sbit, dbit, nbit, src_we, dst_we, last_col, last;
	logic                 out_free;

	// source and destination pixel of the current step
	always_comb begin
		srow = job_q.sr + ((job_q.kind == K_ROT) ? c_q : r_q);
		scol = (job_q.kind == K_ROT) ? job_q.sc + job_q.rw - SUM_W'(1) - r_q
			: job_q.sc + c_q;
		drow = (job_q.kind == K_HFLIP) ? job_q.dr + job_q.rh - SUM_W'(1) - r_q
			: job_q.dr + r_q;
		dcol = (job_q.kind == K_VFLIP) ? job_q.dc + job_q.rw - SUM_W'(1) - c_q
			: job_q.dc + c_q;
	end

	bmb_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_src (
		.clk, .we(src_we), .waddr(srow_q), .wdata(wrow),
		.raddr(srow[RB-1:0]), .rdata(src_rdata)
	);

	bmb_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_dst (
		.clk, .we(dst_we), .waddr(drow_q), .wdata(wrow),
		.raddr(drow[RB-1:0]), .rdata(dst_rdata)
	);

	// rows never written read as cleared
	assign src_row = svld_q ? src_rdata : '0;
	assign dst_row = dvld_q ? dst_rdata : '0;
	assign sbit = src_row[scol_q];
	assign dbit = dst_row[dcol_q];

	always_comb begin
		case (job_q.kind)
			K_WSRC, K_WDST: nbit = job_q.pv;
			K_OR: nbit = sbit | dbit;
			K_XOR: nbit = sbit ^ dbit;
			default: nbit = sbit;
		endcase
		if (job_q.kind == K_WSRC) begin
			wrow = src_row;
			wrow[scol_q] = nbit;
		end else begin
			wrow = dst_row;
			wrow[dcol_q] = nbit;
		end
	end

	assign src_we = (state_q == S_WRITE) && (job_q.kind == K_WSRC);
	assign dst_we = (state_q == S_WRITE) && (job_q.kind != K_WSRC)
		&& (job_q.kind != K_RDST) && (job_q.kind != K_REJ);
	assign last_col = (c_q + SUM_W'(1) == job_q.rw);
	assign last = last_col && (r_q + SUM_W'(1) == job_q.rh);
	assign out_free = !res_valid_q || res_ready;
	assign job_pop = (state_q == S_IDLE) && job_valid;

	assign res_valid = res_valid_q;
	assign res_read = res_read_q;
	assign res_status = res_status_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (job_valid) job_q <= job;
			end
			S_ISSUE: begin
				srow_q <= srow[RB-1:0];
				scol_q <= scol[CB-1:0];
				drow_q <= drow[RB-1:0];
				dcol_q <= dcol[CB-1:0];
				svld_q <= src_vld_q[srow[RB-1:0]];
				dvld_q <= dst_vld_q[drow[RB-1:0]];
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			res_read_q <= rd_q;
			res_status_q <= (job_q.kind == K_REJ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q <= '0;
			c_q <= '0;
			rd_q <= 1'b0;
			res_valid_q <= 1'b0;
			src_vld_q <= '0;
			dst_vld_q <= '0;
		end else begin
			if (state_q == S_DONE && out_free) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			if (src_we) src_vld_q[srow_q] <= 1'b1;
			if (dst_we) dst_vld_q[drow_q] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						r_q <= '0;
						c_q <= '0;
						rd_q <= 1'b0;
						if (job.kind == K_REJ || job.rw == '0 || job.rh == '0)
							state_q <= S_DONE;
						else
							state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WRITE;
				S_WRITE: begin
					if (job_q.kind == K_RDST) rd_q <= dbit;
					if (last_col) begin
						c_q <= '0;
						r_q <= r_q + SUM_W'(1);
					end else begin
						c_q <= c_q + SUM_W'(1);
					end
					state_q <= last ? S_DONE : S_ISSUE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/bitmap_rect_blitter.sv */
// Monochrome blitter over a source and a destination pixel plane, both clear
// after reset. Each command gives exactly one response. Commands pass a
// two-entry queue into an executor that runs one command at a time, visiting
// its pixels one by one (row read from the plane memories, then a
// read-modify-write of one row); a rejected, empty or unknown command visits
// no pixel. Each plane memory has a row-wide read port and a row-wide write
// port. Registers: width at offset 0x0, height at 0x4.
module bitmap_rect_blitter import bmb_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	bmb_req_if.sink      req,
	bmb_rsp_if.source    rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic [6:0] width_q, height_q;
	job_t       fjob, qjob;
	logic       q_full, q_empty, q_pop;

	assign pready = 1'b1;
	assign prdata = {25'd0, paddr[2] ? height_q : width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
			height_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) height_q <= pwdata[6:0];
			else width_q <= pwdata[6:0];
		end
	end

	bmb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.width_reg(width_q), .height_reg(height_q),
		.req_type(req.req_type), .from_col(req.from_col), .from_row(req.from_row),
		.to_col(req.to_col), .to_row(req.to_row), .rect_width(req.rect_width),
		.rect_height(req.rect_height), .pixel_value(req.pixel_value), .job(fjob)
	);

	assign req.ready = !q_full;

	bmb_queue u_queue (
		.clk, .arst_n, .push(req.valid && !q_full), .din(fjob), .full(q_full),
		.pop(q_pop), .dout(qjob), .empty(q_empty)
	);

	bmb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk, .arst_n, .job_valid(!q_empty), .job(qjob), .job_pop(q_pop),
		.res_valid(rsp.valid), .res_ready(rsp.ready), .res_read(rsp.read_value),
		.res_status(rsp.cmd_status)
	);
endmodule

/* src/bmb_checker.sv */
`include "bitmap_rect_blitter_defines.svh"

module bmb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_read_value,
	input logic        rsp_cmd_status,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);
	// stalled response must hold its payload
	`BMB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_cmd_status), "response changed while stalled")
	// a rejected command never returns pixel data
	`BMB_ASSERT(a_rej_zero, rsp_valid && rsp_cmd_status |-> !rsp_read_value, "rejected command returned data")
	// width register reads back what was written
	`BMB_ASSERT(a_cfg_rb, (psel && penable && pwrite && pready && !paddr[2]) ##1 (!paddr[2]) |-> prdata[6:0] == $past(pwdata[6:0]), "width readback mismatch")
	`BMB_ASSERT_ALWAYS(a_pready, pready, "pready low")
endmodule

bind bitmap_rect_blitter bmb_checker u_bmb_checker (
	.clk(clk), .arst_n(arst_n),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_read_value(rsp.read_value), .rsp_cmd_status(rsp.cmd_status),
	.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
	.pwdata(pwdata), .prdata(prdata), .pready(pready)
);

/* dv/bitmap_rect_blitter_test.sv */
`timescale 1ns / 1ps

module bitmap_rect_blitter_test;
	import bmb_pkg::*;

	localparam int PLANE_W = 64;
	localparam int PLANE_H = 64;
	localparam int STALL_LIMIT = 60000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [3:0] op;
		logic [5:0] fc;
		logic [5:0] fr;
		logic [5:0] tc;
		logic [5:0] tr;
		logic [6:0] rw;
		logic [6:0] rh;
		logic       pv;
	} blit_cmd_t;

	typedef struct {
		logic rd;
		logic st;
	} blit_rsp_t;

	class blit_scoreboard;
		bit src_px[PLANE_H][PLANE_W];
		bit dst_px[PLANE_H][PLANE_W];
		logic [6:0] width_reg = 7'd64;
		logic [6:0] height_reg = 7'd64;
		blit_rsp_t pending[$];
		int errors = 0;

		function int act_w();
			if (width_reg == 0) return 1;
			if (width_reg > PLANE_W) return PLANE_W;
			return int'(width_reg);
		endfunction

		function int act_h();
			if (height_reg == 0) return 1;
			if (height_reg > PLANE_H) return PLANE_H;
			return int'(height_reg);
		endfunction

		// one accepted command: update the planes, queue its response
		function void note_cmd(blit_cmd_t c);
			blit_rsp_t e;
			int w, h, rw, rh;
			w = act_w();
			h = act_h();
			rw = int'(c.rw);
			rh = int'(c.rh);
			e.rd = 0;
			e.st = 0;
			if (c.op == REQ_WSRC || c.op == REQ_WDST || c.op == REQ_RDST) begin
				if (c.tc >= w || c.tr >= h)
					e.st = 1;
				else if (c.op == REQ_WSRC)
					src_px[c.tr][c.tc] = c.pv;
				else if (c.op == REQ_WDST)
					dst_px[c.tr][c.tc] = c.pv;
				else
					e.rd = dst_px[c.tr][c.tc];
			end else if (c.op >= REQ_COPY && c.op <= REQ_ROT) begin
				if (c.op == REQ_ROT)
					rh = rw;
				if (c.fc + rw > w || c.tc + rw > w || c.fr + rh > h || c.tr + rh > h)
					e.st = 1;
				else
					for (int r = 0; r < rh; r++)
						for (int k = 0; k < rw; k++)
							case (c.op)
								REQ_COPY: dst_px[c.tr+r][c.tc+k] = src_px[c.fr+r][c.fc+k];
								REQ_VFLIP: dst_px[c.tr+r][c.tc+rw-1-k] = src_px[c.fr+r][c.fc+k];
								REQ_HFLIP: dst_px[c.tr+rh-1-r][c.tc+k] = src_px[c.fr+r][c.fc+k];
								default: dst_px[c.tr+r][c.tc+k] = src_px[c.fr+k][c.fc+rw-1-r];
							endcase
			end else if (c.op == REQ_OR || c.op == REQ_XOR) begin
				for (int r = 0; r < h; r++)
					for (int k = 0; k < w; k++)
						dst_px[r][k] = (c.op == REQ_OR) ? (src_px[r][k] | dst_px[r][k])
							: (src_px[r][k] ^ dst_px[r][k]);
			end else begin
				e.st = 1;
			end
			pending.push_back(e);
		endfunction

		function void check_rsp(logic rd, logic st);
			blit_rsp_t e;
			if (pending.size() == 0) begin
				$error("response with none outstanding: read_value=%0b cmd_status=%0b", rd, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (rd !== e.rd) begin
				$error("read_value: expected %0b, got %0b", e.rd, rd);
				errors++;
			end
			if (st !== e.st) begin
				$error("cmd_status: expected %0b, got %0b", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bmb_req_if req_bus();
	bmb_rsp_if rsp_bus();

	blit_scoreboard sb = new();
	bit calm = 0;
	int quiet_cycles = 0;

	bitmap_rect_blitter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus.sink),
		.rsp(rsp_bus.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	initial begin
		req_bus.valid = 0;
		req_bus.req_type = '0;
		req_bus.from_col = '0;
		req_bus.from_row = '0;
		req_bus.to_col = '0;
		req_bus.to_row = '0;
		req_bus.rect_width = '0;
		req_bus.rect_height = '0;
		req_bus.pixel_value = 0;
		rsp_bus.ready = 0;
	end

	always @(posedge clk)
		rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 35);

	// transaction monitor and stall watchdog
	always @(posedge clk) begin
		blit_cmd_t c;
		bit moved;
		moved = 0;
		if (arst_n && req_bus.valid && req_bus.ready) begin
			c.op = req_bus.req_type;
			c.fc = req_bus.from_col;
			c.fr = req_bus.from_row;
			c.tc = req_bus.to_col;
			c.tr = req_bus.to_row;
			c.rw = req_bus.rect_width;
			c.rh = req_bus.rect_height;
			c.pv = req_bus.pixel_value;
			sb.note_cmd(c);
			moved = 1;
		end
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			sb.check_rsp(rsp_bus.read_value, rsp_bus.cmd_status);
			moved = 1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_cmd(blit_cmd_t c);
		if (!calm && $urandom_range(0, 99) < 35) begin
			req_bus.valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_bus.valid <= 1;
		req_bus.req_type <= c.op;
		req_bus.from_col <= c.fc;
		req_bus.from_row <= c.fr;
		req_bus.to_col <= c.tc;
		req_bus.to_row <= c.tr;
		req_bus.rect_width <= c.rw;
		req_bus.rect_height <= c.rh;
		req_bus.pixel_value <= c.pv;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
	endtask

	// wait until the block has nothing in flight
	task automatic drain();
		req_bus.valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [6:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= {25'd0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == 3'd0)
			sb.width_reg = value;
		else
			sb.height_reg = value;
		@(posedge clk);
	endtask

	task automatic set_size(logic [6:0] w, logic [6:0] h);
		drain();
		reg_write(3'd0, w);
		reg_write(3'd4, h);
	endtask

	function automatic blit_cmd_t mk(logic [3:0] op, int fc, int fr, int tc, int tr,
			int rw, int rh, bit pv);
		blit_cmd_t c;
		c.op = op;
		c.fc = 6'(fc);
		c.fr = 6'(fr);
		c.tc = 6'(tc);
		c.tr = 6'(tr);
		c.rw = 7'(rw);
		c.rh = 7'(rh);
		c.pv = pv;
		return c;
	endfunction

	function automatic blit_cmd_t rand_cmd();
		blit_cmd_t c;
		int w, h, pick, lim_w, lim_h, rw, rh;
		w = sb.act_w();
		h = sb.act_h();
		pick = $urandom_range(0, 99);
		c = mk(REQ_WSRC, $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 64), $urandom_range(0, 64), 1'($urandom_range(0, 1)));
		if (pick < 50) begin
			c.op = (pick < 28) ? REQ_WSRC : (pick < 42) ? REQ_WDST : REQ_RDST;
			if ($urandom_range(0, 99) < 85) begin
				c.tc = 6'($urandom_range(0, w - 1));
				c.tr = 6'($urandom_range(0, h - 1));
			end
		end else if (pick < 90) begin
			c.op = 4'($urandom_range(REQ_COPY, REQ_ROT));
			// mostly small rectangles inside the bitmap, rarely a large one
			if ($urandom_range(0, 99) < 88) begin
				lim_w = ($urandom_range(0, 19) == 0) ? w : (w < 6 ? w : 6);
				lim_h = ($urandom_range(0, 19) == 0) ? h : (h < 6 ? h : 6);
				rw = $urandom_range(0, lim_w);
				rh = $urandom_range(0, lim_h);
				if (c.op == REQ_ROT) begin
					if (rw > h) rw = h;
					rh = rw;
				end
				c.rw = 7'(rw);
				c.rh = (c.op == REQ_ROT) ? 7'($urandom_range(0, 64)) : 7'(rh);
				c.fc = 6'($urandom_range(0, w - rw));
				c.tc = 6'($urandom_range(0, w - rw));
				c.fr = 6'($urandom_range(0, h - rh));
				c.tr = 6'($urandom_range(0, h - rh));
			end
		end else if (pick < 96) begin
			c.op = (pick < 93) ? REQ_OR : REQ_XOR;
		end else begin
			c.op = 4'($urandom_range(9, 15));
		end
		return c;
	endfunction

	task automatic random_burst(int n);
		for (int i = 0; i < n; i++)
			send_cmd(rand_cmd());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: corners, every command, full-size and degenerate rectangles
		send_cmd(mk(REQ_WSRC, 0, 0, 63, 63, 0, 0, 1));
		send_cmd(mk(REQ_WSRC, 0, 0, 0, 0, 0, 0, 1));
		send_cmd(mk(REQ_WSRC, 0, 0, 1, 0, 0, 0, 1));
		send_cmd(mk(REQ_WDST, 0, 0, 42, 21, 0, 0, 1));
		send_cmd(mk(REQ_RDST, 0, 0, 42, 21, 0, 0, 0));
		send_cmd(mk(REQ_RDST, 0, 0, 63, 63, 0, 0, 0));
		send_cmd(mk(REQ_COPY, 0, 0, 0, 0, 64, 64, 0));
		send_cmd(mk(REQ_RDST, 0, 0, 63, 63, 0, 0, 0));
		send_cmd(mk(REQ_VFLIP, 0, 0, 3, 2, 4, 3, 0));
		send_cmd(mk(REQ_HFLIP, 0, 0, 8, 8, 3, 4, 0));
		send_cmd(mk(REQ_ROT, 0, 0, 20, 20, 3, 0, 0));
		send_cmd(mk(REQ_ROT, 62, 62, 0, 0, 2, 64, 0));
		send_cmd(mk(REQ_COPY, 10, 10, 10, 10, 0, 5, 0));
		send_cmd(mk(REQ_COPY, 63, 0, 0, 0, 2, 1, 0));
		send_cmd(mk(REQ_HFLIP, 0, 0, 0, 63, 1, 2, 0));
		send_cmd(mk(REQ_OR, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(REQ_XOR, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(4'd9, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(4'd15, 63, 63, 63, 63, 64, 64, 1));
		send_cmd(mk(REQ_RDST, 0, 0, 0, 0, 0, 0, 0));

		set_size(7'd5, 7'd9);
		send_cmd(mk(REQ_WDST, 0, 0, 5, 0, 0, 0, 1));
		send_cmd(mk(REQ_RDST, 0, 0, 0, 9, 0, 0, 0));
		random_burst(20);

		set_size(7'd0, 7'd127);
		random_burst(12);

		set_size(7'd127, 7'd0);
		random_burst(12);

		set_size(7'd1, 7'd64);
		random_burst(10);

		calm = 1;
		set_size(7'($urandom_range(8, 24)), 7'($urandom_range(8, 24)));
		random_burst(25);
		calm = 0;

		set_size(7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)));
		random_burst(20);

		set_size(7'd64, 7'd64);
		random_burst(18);

		drain();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/bmb_pkg.sv
src/bmb_ifs.sv
src/bmb_ram.sv
src/bmb_front.sv
src/bmb_queue.sv
src/bmb_back.sv
src/bitmap_rect_blitter.sv
src/bmb_checker.sv
dv/bitmap_rect_blitter_test.sv
